### hdl/salc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;
  localparam int unsigned MaxSetBits = 6;
  localparam int unsigned MaxWays = 8;
  localparam int unsigned AddrW = 32;
  localparam int unsigned StampW = 32;
  localparam int unsigned SetIdxW = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int unsigned WayIdxW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned SetCount = 1 << MaxSetBits;
  localparam int unsigned CountW = 32;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpStore = 2'd1;
  localparam logic [1:0] OpModify = 2'd2;
  localparam logic [1:0] OpFetch = 2'd3;

  localparam logic [1:0] OutHit = 2'd0;
  localparam logic [1:0] OutFill = 2'd1;
  localparam logic [1:0] OutEvict = 2'd2;
  localparam logic [1:0] OutNone = 2'd3;

  localparam logic [1:0] CfgSetBits = 2'd0;
  localparam logic [1:0] CfgBlockBits = 2'd1;
  localparam logic [1:0] CfgWays = 2'd2;

  typedef struct packed {
    logic valid;
    logic [AddrW-1:0] tag;
    logic [StampW-1:0] stamp;
  } line_t;

  typedef line_t [MaxWays-1:0] set_line_t;
endpackage
`default_nettype wire

### hdl/salc_set_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module salc_set_mem
  import salc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [SetIdxW-1:0]    rd_addr_i,
  output set_line_t                  rd_data_o,
  input  wire logic                  wr_en_i,
  input  wire logic [SetIdxW-1:0]    wr_addr_i,
  input  wire set_line_t             wr_data_i
);
  // one entry per set holds every way; a set never written reads as all invalid
  set_line_t mem_q [SetCount];
  logic [SetCount-1:0] seen_q;
  set_line_t rd_q;
  logic rd_seen_q;

  // write one set back, read one set, registered
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // track which sets have been written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      rd_seen_q <= 1'b0;
    end else begin
      rd_seen_q <= seen_q[rd_addr_i];
      if (wr_en_i) seen_q[wr_addr_i] <= 1'b1;
    end
  end

  // drop the valid bits of a set that was never written
  always_comb begin
    rd_data_o = rd_q;
    for (int w = 0; w < MaxWays; w++) begin
      rd_data_o[w].valid = rd_q[w].valid & rd_seen_q;
    end
  end
endmodule
`default_nettype wire

### hdl/set_assoc_lru_cache_sim_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a load or store reads its set, then looks it up and writes it back; a modify does
// this twice; a fetch finishes without touching the set memory. A new start is taken only when
// idle; the set memory's single read port and the read-compare-write loop per access set this.
// Reset: asynchronous active low; clears the per-set fill flags, totals, stamp
// clock and config registers at once, no clearing pass. The receiver cannot stall.
module set_assoc_lru_cache_sim_unit
  import salc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] address_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [1:0]       first_outcome_o,
  output logic [1:0]       second_outcome_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o,
  output logic [31:0]      eviction_total_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLook = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] set_bits_q;
  logic [4:0] block_bits_q;
  logic [3:0] ways_q;
  logic [1:0] op_q;
  logic [AddrW-1:0] addr_q;
  logic second_q;
  logic [1:0] first_q;
  logic [StampW-1:0] clock_q;
  logic [CountW-1:0] hits_q, misses_q, evicts_q;

  // config beats, taken only while nothing is in flight
  assign cfg_ready_o = (state_q == StIdle) && !start;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= '0;
      block_bits_q <= '0;
      ways_q <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSetBits:   set_bits_q <= cfg_data_i[2:0];
        CfgBlockBits: block_bits_q <= cfg_data_i[4:0];
        CfgWays:      ways_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // geometry
  logic [3:0] sb;
  logic [4:0] nw;
  logic [6:0] lo;
  logic [AddrW-1:0] set_full;
  logic [SetIdxW-1:0] set_idx;
  logic [AddrW-1:0] tag;
  always_comb begin
    sb = (32'(set_bits_q) > MaxSetBits) ? 4'(MaxSetBits) : {1'b0, set_bits_q};
    nw = (ways_q == 4'd0) ? 5'd1 :
         ((32'(ways_q) > MaxWays) ? 5'(MaxWays) : {1'b0, ways_q});
    lo = 7'(sb) + 7'(block_bits_q);
    set_full = (addr_q >> block_bits_q) & ((AddrW'(1) << sb) - AddrW'(1));
    set_idx = set_full[SetIdxW-1:0];
    tag = (32'(lo) >= AddrW) ? '0 : (addr_q >> lo);
  end

  set_line_t rd_data;
  set_line_t wr_data;
  logic wr_en;
  logic [WayIdxW-1:0] wr_way;

  salc_set_mem u_mem (
    .clk_i, .rst_ni,
    .rd_addr_i(set_idx), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(set_idx), .wr_data_i(wr_data)
  );

  // look up the set: hit, first empty, oldest stamp
  logic hit;
  logic [WayIdxW-1:0] hit_way, empty_way, victim;
  logic has_empty;
  logic [StampW-1:0] best;
  logic [1:0] outcome;
  always_comb begin
    hit = 1'b0; hit_way = '0; has_empty = 1'b0; empty_way = '0;
    victim = '0; best = rd_data[0].valid ? rd_data[0].stamp : '0;
    for (int w = 0; w < MaxWays; w++) begin
      if (5'(w) < nw) begin
        if (rd_data[w].valid) begin
          if (!hit && rd_data[w].tag == tag) begin
            hit = 1'b1; hit_way = WayIdxW'(w);
          end
        end else if (!has_empty) begin
          has_empty = 1'b1; empty_way = WayIdxW'(w);
        end
      end
    end
    for (int w = 1; w < MaxWays; w++) begin
      if (5'(w) < nw &&
          (rd_data[w].valid ? rd_data[w].stamp : '0) < best) begin
        best = rd_data[w].valid ? rd_data[w].stamp : '0;
        victim = WayIdxW'(w);
      end
    end
    outcome = hit ? OutHit : (has_empty ? OutFill : OutEvict);
    wr_way = hit ? hit_way : (has_empty ? empty_way : victim);
    wr_en = (state_q == StLook);
    // write the set back with the chosen way restamped
    wr_data = rd_data;
    wr_data[wr_way].valid = 1'b1;
    wr_data[wr_way].tag = tag;
    wr_data[wr_way].stamp = clock_q + StampW'(1);
  end

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] v);
    return (&v) ? v : v + CountW'(1);
  endfunction

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start && operation_i != OpFetch) state_d = StRead;
      StRead: state_d = StLook;
      StLook: state_d = (op_q == OpModify && !second_q) ? StRead : StIdle;
      default: state_d = StIdle;
    endcase
  end
  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      op_q <= operation_i;
      addr_q <= address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      second_q <= 1'b0;
      first_q <= OutNone;
      clock_q <= '0;
      hits_q <= '0; misses_q <= '0; evicts_q <= '0;
      done_o <= 1'b0;
      first_outcome_o <= OutNone;
      second_outcome_o <= OutNone;
    end else begin
      state_q <= state_d;
      done_o <= 1'b0;
      if (state_q == StIdle && start) begin
        second_q <= 1'b0;
        if (operation_i == OpFetch) begin
          done_o <= 1'b1;
          first_outcome_o <= OutNone;
          second_outcome_o <= OutNone;
        end
      end
      if (state_q == StLook) begin
        clock_q <= clock_q + StampW'(1);
        if (hit) hits_q <= sat_inc(hits_q);
        else misses_q <= sat_inc(misses_q);
        if (outcome == OutEvict) evicts_q <= sat_inc(evicts_q);
        if (op_q == OpModify && !second_q) begin
          second_q <= 1'b1;
          first_q <= outcome;
        end else begin
          done_o <= 1'b1;
          first_outcome_o <= second_q ? first_q : outcome;
          second_outcome_o <= second_q ? outcome : OutNone;
        end
      end
    end
  end

  assign hit_total_o = hits_q;
  assign miss_total_o = misses_q;
  assign eviction_total_o = evicts_q;

  a_write_only_in_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == StLook) else $error("write outside lookup");
  a_read_before_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLook |-> $past(state_q) == StRead) else $error("lookup without read");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == StIdle || state_q == StRead) else $error("bad done");
endmodule
`default_nettype wire
